// File: rtl/assert_macros.svh
// Assertion helpers used by the texture sampler core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/tsb_pkg.sv
package tsb_pkg;

  typedef logic [3:0][7:0] texel_t;

  typedef enum logic {
    REG_TEX_WIDTH  = 1'b0,
    REG_TEX_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [8:0] SIZE_RESET = 9'd256;
  localparam logic signed [29:0] HALF_TEXEL = 30'sd32768;
  localparam logic [8:0] WEIGHT_ONE = 9'd256;
  localparam logic [24:0] BLEND_ROUND = 25'd32768;

  // Clamps a signed texel index to the range [0, size - 1].
  function automatic logic [8:0] clamp_idx(input logic signed [14:0] i,
                                           input logic [8:0] size);
    logic signed [14:0] lim;
    lim = $signed({6'b0, size}) - 15'sd1;
    if (i < 15'sd0) begin
      return '0;
    end else if (i > lim) begin
      return size - 9'd1;
    end else begin
      return i[8:0];
    end
  endfunction

endpackage

// File: rtl/texture_sampler_bilinear_core.sv
// A nearest read passes S_IDX, S_RD0, S_NEAR and S_OUT, a bilinear read S_IDX, S_RD0 to
// S_RD3, S_BOT, S_MIX and S_OUT; a write ends in S_RD0 and gives no result. in_stall is
// high outside S_IDLE, so no item is taken before the last is through; S_OUT waits on
// out_stall. The single-port texel memory serves one access per cycle (four texel reads
// for a bilinear sample). Reset clears the control state and sets both size registers to
// 256; the texel memory is not cleared and must be written before it is read.
`include "assert_macros.svh"

module texture_sampler_bilinear_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic signed [19:0]  u_coord,
  input  logic signed [19:0]  v_coord,
  input  logic                filter_mode,
  input  logic [31:0]         write_texel,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue,
  output logic [7:0]          alpha,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  typedef enum logic [3:0] {
    S_IDLE, S_IDX, S_RD0, S_RD1, S_RD2, S_RD3, S_BOT, S_MIX, S_NEAR, S_OUT
  } state_t;

  state_t state;

  logic [8:0] tex_width;
  logic [8:0] tex_height;
  logic [8:0] w_act;
  logic [8:0] h_act;

  logic                cmd_q;
  logic                bilin_q;
  logic [31:0]         wdata_q;
  logic signed [29:0]  su;
  logic signed [29:0]  sv;
  logic [XW-1:0]       x0;
  logic [XW-1:0]       x1;
  logic [YW-1:0]       y0;
  logic [YW-1:0]       y1;
  logic [7:0]          wu;
  logic [7:0]          wv;

  logic [31:0]         mem [DEPTH];
  logic [AW-1:0]       mem_addr;
  logic                mem_we;
  tsb_pkg::texel_t     rd_data;
  tsb_pkg::texel_t     pix_hold;
  logic [3:0][15:0]    top;
  logic [3:0][15:0]    bot;
  logic [3:0][15:0]    row_next;
  tsb_pkg::texel_t     mix_next;
  tsb_pkg::texel_t     res;

  logic signed [29:0]  su_near;
  logic signed [29:0]  sv_near;
  logic                out_free;

  function automatic logic [AW-1:0] tex_addr(input logic [XW-1:0] x,
                                             input logic [YW-1:0] y);
    return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (tex_width == '0) begin
      w_act = 9'd1;
    end else if (32'(tex_width) > MAX_WIDTH) begin
      w_act = 9'(MAX_WIDTH);
    end else begin
      w_act = tex_width;
    end
    if (tex_height == '0) begin
      h_act = 9'd1;
    end else if (32'(tex_height) > MAX_HEIGHT) begin
      h_act = 9'(MAX_HEIGHT);
    end else begin
      h_act = tex_height;
    end
  end

  assign su_near = su + tsb_pkg::HALF_TEXEL;
  assign sv_near = sv + tsb_pkg::HALF_TEXEL;

  always_comb begin
    unique case (state)
      S_RD1:   mem_addr = tex_addr(x1, y0);
      S_RD2:   mem_addr = tex_addr(x0, y1);
      S_RD3:   mem_addr = tex_addr(x1, y1);
      default: mem_addr = tex_addr(x0, y0);
    endcase
  end

  assign mem_we = (state == S_RD0) && cmd_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= wdata_q;
    end
    rd_data <= mem[mem_addr];
  end

  // One row blend per channel: the held texel on the left, the fresh read on the right.
  always_comb begin
    logic [16:0] acc;
    logic [8:0]  inv_u;
    inv_u = tsb_pkg::WEIGHT_ONE - {1'b0, wu};
    for (int c = 0; c < 4; c++) begin
      acc = 17'(pix_hold[c]) * 17'(inv_u) + 17'(rd_data[c]) * 17'(wu);
      row_next[c] = acc[15:0];
    end
  end

  always_comb begin
    logic [24:0] acc;
    logic [8:0]  inv_v;
    inv_v = tsb_pkg::WEIGHT_ONE - {1'b0, wv};
    for (int c = 0; c < 4; c++) begin
      acc = 25'(top[c]) * 25'(inv_v) + 25'(bot[c]) * 25'(wv) + tsb_pkg::BLEND_ROUND;
      mix_next[c] = acc[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= tsb_pkg::SIZE_RESET;
      tex_height <= tsb_pkg::SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (tsb_pkg::cfg_reg_t'(cfg_index))
        tsb_pkg::REG_TEX_WIDTH:  tex_width  <= cfg_data;
        tsb_pkg::REG_TEX_HEIGHT: tex_height <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q   <= cmd;
            bilin_q <= filter_mode && !cmd;
            wdata_q <= write_texel;
            su      <= u_coord * $signed({1'b0, w_act});
            sv      <= v_coord * $signed({1'b0, h_act});
            state   <= S_IDX;
          end
        end
        S_IDX: begin
          if (bilin_q) begin
            x0 <= XW'(tsb_pkg::clamp_idx(15'($signed(su[29:16])), w_act));
            x1 <= XW'(tsb_pkg::clamp_idx(15'($signed(su[29:16])) + 15'sd1, w_act));
            y0 <= YW'(tsb_pkg::clamp_idx(15'($signed(sv[29:16])), h_act));
            y1 <= YW'(tsb_pkg::clamp_idx(15'($signed(sv[29:16])) + 15'sd1, h_act));
          end else begin
            x0 <= XW'(tsb_pkg::clamp_idx(15'($signed(su_near[29:16])), w_act));
            y0 <= YW'(tsb_pkg::clamp_idx(15'($signed(sv_near[29:16])), h_act));
          end
          wu    <= su[15:8];
          wv    <= sv[15:8];
          state <= S_RD0;
        end
        S_RD0: begin
          priority if (cmd_q) begin
            state <= S_IDLE;
          end else if (bilin_q) begin
            state <= S_RD1;
          end else begin
            state <= S_NEAR;
          end
        end
        S_RD1: begin
          pix_hold <= rd_data;
          state    <= S_RD2;
        end
        S_RD2: begin
          top   <= row_next;
          state <= S_RD3;
        end
        S_RD3: begin
          pix_hold <= rd_data;
          state    <= S_BOT;
        end
        S_BOT: begin
          bot   <= row_next;
          state <= S_MIX;
        end
        S_MIX: begin
          res   <= mix_next;
          state <= S_OUT;
        end
        S_NEAR: begin
          res   <= rd_data;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            red       <= res[0];
            green     <= res[1];
            blue      <= res[2];
            alpha     <= res[3];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `ASSERT_NEXT(a_write_no_result, state == S_RD0 && cmd_q, state == S_IDLE)
  `ASSERT_NEXT(a_result_loaded, state == S_OUT && out_free, out_valid)
  `ASSERT_SAME(a_result_source, $rose(out_valid), $past(state) == S_OUT)

endmodule
